>>> sv/rnst_pkg.sv
// Shared constants, types and helpers for the repeat n-gram spacing table.
package rnst_pkg;

	localparam int TABLE_DEPTH_DEF   = 256;
	localparam int NGRAM_CHARS_DEF   = 3;
	localparam int POSITION_BITS_DEF = 16;

	localparam int COUNT_BITS    = 16;
	localparam int SPACING_BITS  = 16;
	localparam int DISTINCT_BITS = 9;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPD
	} state_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : count_t'(v + 1'b1);
	endfunction

endpackage

>>> sv/rnst_table.sv
// Single-port-write, single-port-read table memory with registered read data.
module rnst_table #(
	parameter int DEPTH = rnst_pkg::TABLE_DEPTH_DEF,
	parameter int WIDTH = 56
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	import rnst_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/repeat_ngram_spacing_table_core.sv
// Top level: Kasiski repeat n-gram table with a sequential linear search.
//
//   channel | signals                                   | role
//   in      | in_valid, in_ready, ngram, position       | n-gram and its position
//   out     | out_valid, out_ready, repeated, spacing,  | one result per n-gram
//           | occurrences, distinct_count,              |
//           | repeat_count, table_full                  |
//
// A lookup reads the used entries in order, one entry per cycle through the single
// memory read port and one key comparator, and stops at the first hit; the update
// state then writes the entry, unless a miss finds the table full.
// Reset clears control and counters only; table entries are never read
// before written. A result waits in the output register; in_ready returns
// as soon as the update has moved the result there.
module repeat_ngram_spacing_table_core #(
	parameter int TABLE_DEPTH   = rnst_pkg::TABLE_DEPTH_DEF,
	parameter int NGRAM_CHARS   = rnst_pkg::NGRAM_CHARS_DEF,
	parameter int POSITION_BITS = rnst_pkg::POSITION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [NGRAM_CHARS*8-1:0]          ngram,
	input  logic [POSITION_BITS-1:0]          position,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              repeated,
	output logic [rnst_pkg::SPACING_BITS-1:0] spacing,
	output logic [rnst_pkg::COUNT_BITS-1:0]   occurrences,
	output logic [rnst_pkg::DISTINCT_BITS-1:0] distinct_count,
	output logic [rnst_pkg::COUNT_BITS-1:0]   repeat_count,
	output logic                              table_full
);
	import rnst_pkg::*;

	localparam int KEY_BITS   = NGRAM_CHARS * 8;
	localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
	localparam int USED_BITS  = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_BITS = KEY_BITS + POSITION_BITS + COUNT_BITS;
	localparam logic [USED_BITS-1:0] DEPTH_U = USED_BITS'(TABLE_DEPTH);

	state_t state_q, state_n;

	logic [KEY_BITS-1:0]      key_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [USED_BITS-1:0]     addr_q;
	logic [IDX_BITS-1:0]      cmp_idx_q;
	logic                     pend_q;
	logic                     found_q;
	logic [USED_BITS-1:0]     used_q;
	count_t                   rep_q;
	logic                     out_valid_q;

	logic                  mem_we, mem_re;
	logic [IDX_BITS-1:0]   mem_waddr;
	logic [ENTRY_BITS-1:0] mem_wdata, mem_rdata;

	logic [KEY_BITS-1:0]      rd_key;
	logic [POSITION_BITS-1:0] rd_pos;
	count_t                   rd_cnt;

	logic hit, more, accept, out_free, fire, has_room;
	logic [POSITION_BITS-1:0]              diff;
	logic [POSITION_BITS+SPACING_BITS-1:0] diff_ext;
	logic [USED_BITS-1:0]                  used_inc;
	logic [USED_BITS+DISTINCT_BITS-1:0]    used_ext;
	count_t                                occ_inc;

	assign {rd_key, rd_pos, rd_cnt} = mem_rdata;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign hit      = pend_q && (rd_key == key_q);
	assign more     = addr_q < used_q;
	assign has_room = used_q < DEPTH_U;
	assign diff     = pos_q - rd_pos;
	assign diff_ext = {{SPACING_BITS{1'b0}}, diff};
	assign occ_inc  = sat_inc(rd_cnt);
	assign used_inc = used_q + 1'b1;
	assign used_ext = {{DISTINCT_BITS{1'b0}}, used_inc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		in_ready  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cmp_idx_q;
		mem_wdata = {key_q, pos_q, occ_inc};
		fire      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_n = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_n = ST_UPD;
				end else if (more) begin
					mem_re = 1'b1;
				end else begin
					state_n = ST_UPD;
				end
			end
			ST_UPD: begin
				if (out_free) begin
					fire    = 1'b1;
					state_n = ST_IDLE;
					if (found_q) begin
						mem_we = 1'b1;
					end else if (has_room) begin
						mem_we    = 1'b1;
						mem_waddr = used_q[IDX_BITS-1:0];
						mem_wdata = {key_q, pos_q, count_t'(1)};
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			found_q <= 1'b0;
			addr_q  <= '0;
			used_q  <= '0;
			rep_q   <= '0;
		end else begin
			if (accept) begin
				pend_q  <= 1'b0;
				found_q <= 1'b0;
				addr_q  <= '0;
			end else if (state_q == ST_SCAN) begin
				if (hit) begin
					found_q <= 1'b1;
				end else if (more) begin
					addr_q <= addr_q + 1'b1;
					pend_q <= 1'b1;
				end
			end
			if (fire) begin
				if (found_q) begin
					rep_q <= sat_inc(rep_q);
				end else if (has_room) begin
					used_q <= used_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= ngram;
			pos_q <= position;
		end
		if (mem_re) begin
			cmp_idx_q <= addr_q[IDX_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			repeat_count <= rep_q;
			repeated     <= 1'b0;
			spacing      <= '0;
			occurrences  <= '0;
			table_full   <= 1'b0;
			distinct_count <= used_ext[DISTINCT_BITS-1:0] - 1'b1;
			if (found_q) begin
				repeated     <= 1'b1;
				spacing      <= diff_ext[SPACING_BITS-1:0];
				occurrences  <= occ_inc;
				repeat_count <= sat_inc(rep_q);
			end else if (has_room) begin
				occurrences    <= count_t'(1);
				distinct_count <= used_ext[DISTINCT_BITS-1:0];
			end else begin
				table_full <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

	rnst_table #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(ENTRY_BITS)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(addr_q[IDX_BITS-1:0]),
		.rdata(mem_rdata)
	);

endmodule

>>> sv/rnst_checker.sv
// Port-level checks for the repeat n-gram spacing table, bound to the top level.
module rnst_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               repeated,
	input logic [rnst_pkg::SPACING_BITS-1:0]  spacing,
	input logic [rnst_pkg::COUNT_BITS-1:0]    occurrences,
	input logic [rnst_pkg::DISTINCT_BITS-1:0] distinct_count,
	input logic [rnst_pkg::COUNT_BITS-1:0]    repeat_count,
	input logic                               table_full
);
	import rnst_pkg::*;

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !repeated && spacing == '0 && occurrences == '0)
		else $error("dropped n-gram reports repeat data");

	a_new_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !repeated && !table_full |->
			spacing == '0 && occurrences == 1 && distinct_count != '0)
		else $error("new n-gram result inconsistent");

	a_rep_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && repeated |-> occurrences >= 2 && repeat_count != '0 && !table_full)
		else $error("repeat result inconsistent");

	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(occurrences) && $stable(spacing))
		else $error("stalled result changed");

endmodule

bind repeat_ngram_spacing_table_core rnst_checker u_rnst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.repeated      (repeated),
	.spacing       (spacing),
	.occurrences   (occurrences),
	.distinct_count(distinct_count),
	.repeat_count  (repeat_count),
	.table_full    (table_full)
);

>>> sim/tb_repeat_ngram_spacing_table_core.sv
// Self-checking testbench for the repeat n-gram spacing table core.
module tb_repeat_ngram_spacing_table_core;
	import rnst_pkg::*;

	localparam int NGRAM_W   = NGRAM_CHARS_DEF * 8;
	localparam int POS_W     = POSITION_BITS_DEF;
	localparam int DEPTH     = TABLE_DEPTH_DEF;
	localparam int POOL_SIZE = 320;
	localparam logic [NGRAM_W-1:0] SAT_NGRAM = 24'h5A5A5A;

	typedef logic [NGRAM_W-1:0] ngram_t;
	typedef logic [POS_W-1:0]   pos_t;

	typedef struct packed {
		logic                     repeated;
		logic [SPACING_BITS-1:0]  spacing;
		count_t                   occurrences;
		logic [DISTINCT_BITS-1:0] distinct_count;
		count_t                   repeat_count;
		logic                     table_full;
	} spacing_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ngram_t ngram = '0;
	pos_t position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic repeated;
	logic [SPACING_BITS-1:0] spacing;
	count_t occurrences;
	logic [DISTINCT_BITS-1:0] distinct_count;
	count_t repeat_count;
	logic table_full;

	// predicted table contents
	ngram_t tbl_key [DEPTH];
	pos_t   tbl_last_pos [DEPTH];
	count_t tbl_occ [DEPTH];
	int     tbl_used = 0;
	count_t total_spacings = '0;

	spacing_result_t pending_results [$];
	ngram_t ngram_pool [POOL_SIZE];
	pos_t   pos_cursor = '0;
	int     send_pct = 0;
	int     recv_pct = 0;
	int     errors = 0;

	repeat_ngram_spacing_table_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.ngram          (ngram),
		.position       (position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.repeated       (repeated),
		.spacing        (spacing),
		.occurrences    (occurrences),
		.distinct_count (distinct_count),
		.repeat_count   (repeat_count),
		.table_full     (table_full)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("repeat_ngram_spacing_table_core test failed");
		$finish;
	end

	function automatic spacing_result_t record_ngram(input ngram_t g, input pos_t p);
		spacing_result_t r;
		pos_t diff;
		int slot;
		int s;
		slot = -1;
		for (s = 0; s < tbl_used; s++) begin
			if (tbl_key[s] == g) begin
				slot = s;
				break;
			end
		end
		r = '0;
		if (slot >= 0) begin
			diff = p - tbl_last_pos[slot];
			r.repeated = 1'b1;
			r.spacing = diff;
			tbl_last_pos[slot] = p;
			if (tbl_occ[slot] != '1)
				tbl_occ[slot] = tbl_occ[slot] + 1'b1;
			if (total_spacings != '1)
				total_spacings = total_spacings + 1'b1;
			r.occurrences = tbl_occ[slot];
		end else if (tbl_used < DEPTH) begin
			tbl_key[tbl_used] = g;
			tbl_last_pos[tbl_used] = p;
			tbl_occ[tbl_used] = count_t'(1);
			tbl_used++;
			r.occurrences = count_t'(1);
		end else begin
			r.table_full = 1'b1;
		end
		r.distinct_count = DISTINCT_BITS'(tbl_used);
		r.repeat_count = total_spacings;
		return r;
	endfunction

	function automatic pos_t next_position();
		if ($urandom_range(9) == 0)
			pos_cursor = pos_t'($urandom);
		else
			pos_cursor = pos_cursor + pos_t'($urandom_range(1, 40));
		return pos_cursor;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// called just after a rising edge; returns just after the accepting edge
	task automatic send_ngram(input ngram_t g, input pos_t p);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ngram <= g;
		position <= p;
		do @(posedge clk); while (!(in_valid && in_ready));
		pending_results.push_back(record_ngram(g, p));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_pct);
	end

	always @(posedge clk) begin
		spacing_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing pending");
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("repeated", 32'(want.repeated), 32'(repeated));
				check_field("spacing", 32'(want.spacing), 32'(spacing));
				check_field("occurrences", 32'(want.occurrences), 32'(occurrences));
				check_field("distinct_count", 32'(want.distinct_count),
					32'(distinct_count));
				check_field("repeat_count", 32'(want.repeat_count), 32'(repeat_count));
				check_field("table_full", 32'(want.table_full), 32'(table_full));
			end
		end
	end

	// one n-gram sent over and over while the table is tiny: occurrence and
	// repeat counts climb, some repeats land on the same position
	task automatic test_repeated_ngram();
		pos_t p;
		p = pos_t'($urandom);
		send_pct = 0;
		recv_pct = 0;
		repeat (60) begin
			send_ngram(SAT_NGRAM, p);
			p = p + pos_t'($urandom_range(0, 3));
		end
	endtask

	task automatic test_directed_extremes();
		send_pct = 0;
		recv_pct = 0;
		send_ngram(24'h000000, 16'h0000);
		send_ngram(24'hFFFFFF, 16'hFFFF);
		send_ngram(24'h000000, 16'h0000);
		send_ngram(24'hFFFFFF, 16'h0002);
		send_ngram(24'h000001, 16'hFFFF);
		send_ngram(24'h800000, 16'h0001);
		send_ngram(24'h000000, 16'hFFFF);
		send_ngram(24'h800000, 16'h0001);
		send_ngram(SAT_NGRAM, 16'h0000);
		send_ngram(24'hFFFFFE, 16'h8000);
		send_ngram(24'hFFFFFF, 16'h8000);
		send_ngram(24'h000001, 16'h7FFF);
	endtask

	// mostly n-grams from a pool (repeats with random spacing), some noise
	task automatic test_random_traffic(input int sp, input int rp, input int count);
		ngram_t g;
		send_pct = sp;
		recv_pct = rp;
		repeat (count) begin
			if ($urandom_range(3) != 0)
				g = ngram_pool[$urandom_range(POOL_SIZE - 1)];
			else
				g = ngram_t'($urandom);
			send_ngram(g, next_position());
		end
	endtask

	task automatic test_table_full();
		int n;
		send_pct = 10;
		recv_pct = 10;
		while (tbl_used < DEPTH)
			send_ngram(ngram_t'($urandom), next_position());
		send_ngram(tbl_key[0], next_position());
		send_ngram(tbl_key[DEPTH-1], next_position());
		for (n = 0; n < 24; n++) begin
			if (n % 3 == 0)
				send_ngram(tbl_key[$urandom_range(DEPTH - 1)], next_position());
			else
				send_ngram(ngram_t'($urandom), next_position());
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < POOL_SIZE; i++) begin
			if (i > 0 && $urandom_range(3) == 0)
				ngram_pool[i] = ngram_pool[$urandom_range(i - 1)]
					^ (ngram_t'(1) << $urandom_range(NGRAM_W - 1));
			else
				ngram_pool[i] = ngram_t'($urandom);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_repeated_ngram();
		wait_for_results();
		test_directed_extremes();
		wait_for_results();
		test_random_traffic(0, 0, 280);
		wait_for_results();
		test_random_traffic(53, 0, 280);
		wait_for_results();
		test_random_traffic(0, 53, 280);
		wait_for_results();
		test_random_traffic(10, 10, 280);
		test_table_full();

		in_valid <= 1'b0;
		for (i = 0; i < 100000 && pending_results.size() != 0; i++)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("repeat_ngram_spacing_table_core test passed");
		else
			$display("repeat_ngram_spacing_table_core test failed");
		$finish;
	end

endmodule
